>>> rtl/sfr_pkg.sv
// Shared types, constants and codes for the sensor frame receiver.
package sfr_pkg;

  // Payload store and field sizes.
  localparam int MAX_PAYLOAD = 32;
  localparam int IDX_W       = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = 6;
  localparam int POS_W       = 6;
  localparam int BYTE_W      = 8;
  localparam int CNT_W       = 16;
  localparam int TDATA_W     = 72;

  // Command queue between the parser and the emitter.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Frame framing constants.
  localparam logic [BYTE_W-1:0] START_BYTE  = 8'h25;
  localparam logic [POS_W-1:0]  HEADER_LEN  = 6'd4;

  // Register reset values.
  localparam logic [BYTE_W-1:0] TYPE_A_RESET = 8'd66;
  localparam logic [BYTE_W-1:0] TYPE_B_RESET = 8'd76;
  localparam logic [LEN_W-1:0]  LEN_A_RESET  = 6'd8;
  localparam logic [LEN_W-1:0]  LEN_B_RESET  = 6'd12;

  typedef enum logic [1:0] {
    REG_TYPE_A = 2'd0,
    REG_TYPE_B = 2'd1,
    REG_LEN_A  = 2'd2,
    REG_LEN_B  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_TYPE = 3'd1,
    PH_ADDR = 3'd2,
    PH_LEN  = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_GOOD   = 2'd1,
    ST_BADSUM = 2'd2,
    ST_RXERR  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    EM_IDLE = 2'd0,
    EM_WAIT = 2'd1,
    EM_DATA = 2'd2,
    EM_STAT = 2'd3
  } emit_state_t;

  // Configuration as seen by the parser.
  typedef struct packed {
    logic [BYTE_W-1:0] type_code_a;
    logic [BYTE_W-1:0] type_code_b;
    logic [LEN_W-1:0]  length_a;
    logic [LEN_W-1:0]  length_b;
  } cfg_t;

  // One parsed input beat: what the emitter has to send for it.
  typedef struct packed {
    logic              burst;
    status_t           status;
    logic              sensor_kind;
    logic [BYTE_W-1:0] frame_addr;
    logic [LEN_W-1:0]  length;
    logic [CNT_W-1:0]  count_a;
    logic [CNT_W-1:0]  count_b;
    logic [CNT_W-1:0]  error_count;
  } cmd_t;

endpackage

>>> rtl/sfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/sfr_parser.sv
// Front end: accepts received beats, runs the frame parser and queues commands.
module sfr_parser import sfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_error,
  input  logic              back_busy,
  input  logic              queue_full,
  output logic              push,
  output cmd_t              push_data,
  output logic              ram_we,
  output logic [IDX_W-1:0]  ram_waddr,
  output logic [BYTE_W-1:0] ram_wdata
);

  phase_t            phase, phase_next;
  logic [POS_W-1:0]  position, position_next;
  logic [BYTE_W-1:0] running_xor, running_xor_next;
  logic              cur_kind, cur_kind_next;
  logic [BYTE_W-1:0] cur_addr, cur_addr_next;
  logic [LEN_W-1:0]  frame_len, frame_len_next;
  logic [CNT_W-1:0]  count_a, count_a_next;
  logic [CNT_W-1:0]  count_b, count_b_next;
  logic [CNT_W-1:0]  err_count, err_count_next;

  logic              accept;
  logic              is_payload;
  logic              is_sum;
  logic              burst;
  logic              store_wr;
  status_t           status;
  logic [LEN_W-1:0]  want;
  logic [POS_W-1:0]  data_end;
  logic [POS_W-1:0]  store_pos;

  assign data_end   = HEADER_LEN + POS_W'(frame_len);
  assign is_payload = (position < data_end);
  assign is_sum     = (position == data_end);
  assign store_pos  = position - HEADER_LEN;
  assign want       = cur_kind ? cfg.length_b : cfg.length_a;

  // A payload byte must not overwrite the store while a burst is still pending.
  assign in_ready = !queue_full && !((phase == PH_DATA) && is_payload && back_busy);
  assign accept   = in_valid && in_ready;

  // Parser state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      position    <= '0;
      running_xor <= '0;
      cur_kind    <= 1'b0;
      cur_addr    <= '0;
      frame_len   <= '0;
      count_a     <= '0;
      count_b     <= '0;
      err_count   <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      position    <= position_next;
      running_xor <= running_xor_next;
      cur_kind    <= cur_kind_next;
      cur_addr    <= cur_addr_next;
      frame_len   <= frame_len_next;
      count_a     <= count_a_next;
      count_b     <= count_b_next;
      err_count   <= err_count_next;
    end
  end

  // Next state of the parser for the beat on the input.
  always_comb begin
    phase_next       = phase;
    position_next    = position;
    running_xor_next = running_xor;
    cur_kind_next    = cur_kind;
    cur_addr_next    = cur_addr;
    frame_len_next   = frame_len;
    count_a_next     = count_a;
    count_b_next     = count_b;
    err_count_next   = err_count;
    status           = ST_NONE;
    burst            = 1'b0;
    store_wr         = 1'b0;

    if (in_error) begin
      // A receive error drops the frame and restarts the hunt.
      phase_next       = PH_HUNT;
      position_next    = '0;
      running_xor_next = '0;
      err_count_next   = err_count + CNT_W'(1);
      status           = ST_RXERR;
    end else begin
      unique case (phase)
        PH_TYPE: begin
          if ((in_byte == cfg.type_code_a) || (in_byte == cfg.type_code_b)) begin
            cur_kind_next    = (in_byte != cfg.type_code_a);
            running_xor_next = running_xor ^ in_byte;
            position_next    = position + POS_W'(1);
            phase_next       = PH_ADDR;
          end else begin
            phase_next       = PH_HUNT;
            position_next    = '0;
            running_xor_next = '0;
          end
        end
        PH_ADDR: begin
          cur_addr_next    = in_byte;
          running_xor_next = running_xor ^ in_byte;
          position_next    = position + POS_W'(1);
          phase_next       = PH_LEN;
        end
        PH_LEN: begin
          if ((want != '0) && (want <= LEN_W'(MAX_PAYLOAD)) &&
              (in_byte == BYTE_W'(want))) begin
            frame_len_next   = want;
            running_xor_next = running_xor ^ in_byte;
            position_next    = position + POS_W'(1);
            phase_next       = PH_DATA;
          end else begin
            phase_next       = PH_HUNT;
            position_next    = '0;
            running_xor_next = '0;
          end
        end
        PH_DATA: begin
          if (is_payload) begin
            store_wr         = 1'b1;
            running_xor_next = running_xor ^ in_byte;
            position_next    = position + POS_W'(1);
          end else if (is_sum) begin
            running_xor_next = running_xor ^ in_byte;
            position_next    = position + POS_W'(1);
          end else begin
            // Trailer byte: the frame is judged on the checksum.
            if (running_xor == '0) begin
              if (cur_kind) begin
                count_b_next = count_b + CNT_W'(1);
              end else begin
                count_a_next = count_a + CNT_W'(1);
              end
              burst  = 1'b1;
              status = ST_GOOD;
            end else begin
              status = ST_BADSUM;
            end
            phase_next       = PH_HUNT;
            position_next    = '0;
            running_xor_next = '0;
          end
        end
        default: begin
          // Hunting for the start byte.
          phase_next       = PH_HUNT;
          position_next    = '0;
          running_xor_next = '0;
          if (in_byte == START_BYTE) begin
            running_xor_next = in_byte;
            position_next    = POS_W'(1);
            phase_next       = PH_TYPE;
          end
        end
      endcase
    end
  end

  // Payload store write.
  assign ram_we    = accept && store_wr;
  assign ram_waddr = store_pos[IDX_W-1:0];
  assign ram_wdata = in_byte;

  // One command per accepted beat.
  assign push                  = accept;
  assign push_data.burst       = burst;
  assign push_data.status      = status;
  assign push_data.sensor_kind = cur_kind_next;
  assign push_data.frame_addr  = cur_addr_next;
  assign push_data.length      = frame_len;
  assign push_data.count_a     = count_a_next;
  assign push_data.count_b     = count_b_next;
  assign push_data.error_count = err_count_next;

endmodule

>>> rtl/sfr_cmd_fifo.sv
// Short command queue between the parser and the emitter.
module sfr_cmd_fifo import sfr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

>>> rtl/sfr_emitter.sv
// Back end: turns queued commands into payload and status result beats.
module sfr_emitter import sfr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               queue_empty,
  output logic               pop,
  input  cmd_t               cmd,
  output logic               busy,
  output logic [IDX_W-1:0]   ram_raddr,
  input  logic [BYTE_W-1:0]  ram_rdata,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [TDATA_W-1:0] out_data,
  output logic               out_kind,
  output logic               out_last
);

  emit_state_t      state, state_next;
  cmd_t             cur, cur_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             out_free;
  logic             load_pay;
  logic             load_stat;
  logic             last_byte;

  assign out_free  = !out_valid || out_ready;
  assign last_byte = ((LEN_W'(idx) + LEN_W'(1)) == cur.length);
  assign ram_raddr = idx;
  assign busy      = (state != EM_IDLE);

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= EM_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
  end

  // Next state: one payload beat per read of the store, then the status beat.
  always_comb begin
    state_next = state;
    cur_next   = cur;
    idx_next   = idx;
    pop        = 1'b0;
    load_pay   = 1'b0;
    load_stat  = 1'b0;
    unique case (state)
      EM_IDLE: begin
        if (!queue_empty) begin
          pop        = 1'b1;
          cur_next   = cmd;
          idx_next   = '0;
          state_next = cmd.burst ? EM_WAIT : EM_STAT;
        end
      end
      EM_WAIT: begin
        state_next = EM_DATA;
      end
      EM_DATA: begin
        if (out_free) begin
          load_pay = 1'b1;
          if (last_byte) begin
            state_next = EM_STAT;
          end else begin
            idx_next   = idx + IDX_W'(1);
            state_next = EM_WAIT;
          end
        end
      end
      EM_STAT: begin
        if (out_free) begin
          load_stat  = 1'b1;
          state_next = EM_IDLE;
        end
      end
      default: begin
        state_next = EM_IDLE;
      end
    endcase
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_pay || load_stat) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (load_pay || load_stat) begin
      out_kind <= load_pay;
      out_last <= load_stat;
      out_data <= {cur.error_count, cur.count_b, cur.count_a,
                   load_pay ? idx : IDX_W'(0),
                   load_pay ? ram_rdata : BYTE_W'(0),
                   cur.frame_addr, cur.sensor_kind, cur.status};
    end
  end

endmodule

>>> rtl/sensor_frame_receiver_unit.sv
// Top level of the sensor frame receiver: register port, parser, queue, emitter.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata: rx_byte; tuser: rx_error
//  m_axis    out        tdata: status..rx_error_count; tuser: kind; tlast: last
//  APB       in/out     four registers at byte addresses 0, 4, 8, 12
//
// The parser handles each accepted input beat; the emitter pops a command, then passes
// each payload byte through a store read state and an output load state, then the status beat.
// Reset is synchronous; the payload store is not cleared.
// A full command queue, or a busy back end when a payload byte arrives, stalls s_axis.
module sensor_frame_receiver_unit import sfr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // Input stream.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
  input  logic               s_axis_tuser,   // [0] rx_error
  // Output stream.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [1:0] status, [2] sensor_kind, [10:3] frame_addr, [18:11] payload_byte,
  // [23:19] payload_index, [39:24] good_count_a, [55:40] good_count_b,
  // [71:56] rx_error_count
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic               m_axis_tuser,   // [0] kind
  output logic               m_axis_tlast,
  // Register port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t              cfg;
  reg_idx_t          reg_sel;
  logic              reg_wr;
  cmd_t              push_data;
  cmd_t              pop_data;
  logic              push;
  logic              pop;
  logic              queue_full;
  logic              queue_empty;
  logic              emit_busy;
  logic              back_busy;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.type_code_a <= TYPE_A_RESET;
      cfg.type_code_b <= TYPE_B_RESET;
      cfg.length_a    <= LEN_A_RESET;
      cfg.length_b    <= LEN_B_RESET;
    end else if (reg_wr) begin
      unique case (reg_sel)
        REG_TYPE_A: cfg.type_code_a <= pwdata[BYTE_W-1:0];
        REG_TYPE_B: cfg.type_code_b <= pwdata[BYTE_W-1:0];
        REG_LEN_A:  cfg.length_a    <= pwdata[LEN_W-1:0];
        REG_LEN_B:  cfg.length_b    <= pwdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_sel)
      REG_TYPE_A: prdata = 32'(cfg.type_code_a);
      REG_TYPE_B: prdata = 32'(cfg.type_code_b);
      REG_LEN_A:  prdata = 32'(cfg.length_a);
      REG_LEN_B:  prdata = 32'(cfg.length_b);
      default:    prdata = '0;
    endcase
  end

  assign back_busy = emit_busy || !queue_empty;

  sfr_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_error   (s_axis_tuser),
    .back_busy  (back_busy),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata)
  );

  sfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sfr_cmd_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (queue_empty)
  );

  sfr_emitter u_emitter (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .pop         (pop),
    .cmd         (pop_data),
    .busy        (emit_busy),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (m_axis_tdata),
    .out_kind    (m_axis_tuser),
    .out_last    (m_axis_tlast)
  );

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the sensor frame receiver unit.
module testbench;
  import sfr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_LIMIT    = 50;

  // One received byte as it goes into the input stream.
  typedef struct {
    logic [7:0] data;
    logic       err;
  } rx_item_t;

  // One output beat as the unit is expected to produce it.
  typedef struct packed {
    logic              kind;
    status_t           status;
    logic              sensor_kind;
    logic [7:0]        address;
    logic [7:0]        payload;
    logic [IDX_W-1:0]  index;
    logic              last;
    logic [CNT_W-1:0]  count_a;
    logic [CNT_W-1:0]  count_b;
    logic [CNT_W-1:0]  count_err;
  } result_beat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata = '0;   // [7:0] rx_byte
  logic               s_axis_tuser = 1'b0; // [0] rx_error
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  // [1:0] status, [2] sensor_kind, [10:3] frame_addr, [18:11] payload_byte,
  // [23:19] payload_index, [39:24] good_count_a, [55:40] good_count_b,
  // [71:56] rx_error_count
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               m_axis_tuser;        // [0] kind
  logic               m_axis_tlast;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  sensor_frame_receiver_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk = ~clk;

  // Register copies used by the frame parser model.
  logic [7:0]       code_a = TYPE_A_RESET;
  logic [7:0]       code_b = TYPE_B_RESET;
  logic [LEN_W-1:0] len_a  = LEN_A_RESET;
  logic [LEN_W-1:0] len_b  = LEN_B_RESET;

  // Parser model state.
  phase_t           frame_state = PH_HUNT;
  logic [POS_W-1:0] frame_pos = '0;
  logic [7:0]       frame_xor = '0;
  logic             latched_kind = 1'b0;
  logic [7:0]       latched_addr = '0;
  logic [LEN_W-1:0] latched_len = '0;
  logic [7:0]       payload_mem [MAX_PAYLOAD];
  logic [CNT_W-1:0] frames_a = '0;
  logic [CNT_W-1:0] frames_b = '0;
  logic [CNT_W-1:0] rx_errors_seen = '0;

  rx_item_t     pending_bytes [$];
  result_beat_t expected_beats [$];
  rx_item_t     next_item;
  int           queued_total = 0;
  int           mismatches = 0;
  int           beat_no = 0;
  int           src_gap = 0;
  int           sink_stall = 0;
  int           stuck_cycles = 0;
  bit           no_idle = 0;

  function automatic void restart_hunt();
    frame_state = PH_HUNT;
    frame_pos   = '0;
    frame_xor   = '0;
  endfunction

  // Queue one expected beat built from the current frame state and counters.
  function automatic void push_result(logic is_payload, status_t st, logic [7:0] pb,
                                      logic [IDX_W-1:0] idx);
    result_beat_t r;
    r.kind        = is_payload;
    r.status      = st;
    r.sensor_kind = latched_kind;
    r.address     = latched_addr;
    r.payload     = pb;
    r.index       = idx;
    r.last        = !is_payload;
    r.count_a     = frames_a;
    r.count_b     = frames_b;
    r.count_err   = rx_errors_seen;
    expected_beats.push_back(r);
  endfunction

  // Advance the frame parser model by one received byte and queue its beats.
  function automatic void parse_byte(logic [7:0] b, logic err);
    status_t          st;
    logic [LEN_W-1:0] want;
    logic [POS_W-1:0] off;
    st = ST_NONE;
    if (err) begin
      restart_hunt();
      rx_errors_seen = rx_errors_seen + 1'b1;
      push_result(1'b0, ST_RXERR, '0, '0);
      return;
    end
    case (frame_state)
      PH_TYPE: begin
        if (b == code_a || b == code_b) begin
          latched_kind = (b != code_a);
          frame_xor    = frame_xor ^ b;
          frame_pos    = frame_pos + 1'b1;
          frame_state  = PH_ADDR;
        end else begin
          restart_hunt();
        end
      end
      PH_ADDR: begin
        latched_addr = b;
        frame_xor    = frame_xor ^ b;
        frame_pos    = frame_pos + 1'b1;
        frame_state  = PH_LEN;
      end
      PH_LEN: begin
        want = latched_kind ? len_b : len_a;
        if (want >= 1 && want <= MAX_PAYLOAD && b == {2'b00, want}) begin
          latched_len = want;
          frame_xor   = frame_xor ^ b;
          frame_pos   = frame_pos + 1'b1;
          frame_state = PH_DATA;
        end else begin
          restart_hunt();
        end
      end
      PH_DATA: begin
        if (int'(frame_pos) < int'(HEADER_LEN) + int'(latched_len)) begin
          off = frame_pos - HEADER_LEN;
          payload_mem[off[IDX_W-1:0]] = b;
          frame_xor = frame_xor ^ b;
          frame_pos = frame_pos + 1'b1;
        end else if (int'(frame_pos) == int'(HEADER_LEN) + int'(latched_len)) begin
          // Checksum byte.
          frame_xor = frame_xor ^ b;
          frame_pos = frame_pos + 1'b1;
        end else begin
          // Trailer byte: the frame is judged here.
          if (frame_xor == 8'h00) begin
            if (latched_kind) frames_b = frames_b + 1'b1;
            else frames_a = frames_a + 1'b1;
            for (int i = 0; i < int'(latched_len); i++)
              push_result(1'b1, ST_GOOD, payload_mem[i], IDX_W'(i));
            st = ST_GOOD;
          end else begin
            st = ST_BADSUM;
          end
          restart_hunt();
        end
      end
      default: begin
        restart_hunt();
        if (b == START_BYTE) begin
          frame_xor   = b;
          frame_pos   = POS_W'(1);
          frame_state = PH_TYPE;
        end
      end
    endcase
    push_result(1'b0, st, '0, '0);
  endfunction

  function automatic void push_item(logic [7:0] data, logic err);
    rx_item_t it;
    it.data = data;
    it.err  = err;
    pending_bytes.push_back(it);
    queued_total++;
  endfunction

  // Queue a complete frame; the checksum makes the XOR zero unless corrupted.
  function automatic void queue_frame(logic sel_b, logic [7:0] addr, logic [7:0] len_byte,
                                      int plen, bit bad_sum);
    logic [7:0] code;
    logic [7:0] sum;
    logic [7:0] pb;
    code = sel_b ? code_b : code_a;
    sum  = START_BYTE ^ code ^ addr ^ len_byte;
    push_item(START_BYTE, 1'b0);
    push_item(code, 1'b0);
    push_item(addr, 1'b0);
    push_item(len_byte, 1'b0);
    for (int i = 0; i < plen; i++) begin
      pb  = 8'($urandom_range(0, 255));
      sum = sum ^ pb;
      push_item(pb, 1'b0);
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    push_item(sum, 1'b0);
    push_item(8'($urandom_range(0, 255)), 1'b0);
  endfunction

  // Mostly well-formed frames, with broken frames, receive errors and noise mixed in.
  function automatic void queue_random(int count);
    int               start;
    int               pick;
    int               plen;
    logic             sel_b;
    logic [LEN_W-1:0] want;
    logic [7:0]       t;
    start = queued_total;
    while (queued_total - start < count) begin
      pick  = $urandom_range(0, 19);
      sel_b = 1'($urandom_range(0, 1));
      want  = (sel_b && code_b != code_a) ? len_b : len_a;
      plen  = (want >= 1 && want <= MAX_PAYLOAD) ? int'(want) : int'($urandom_range(1, 3));
      if (pick < 12) begin
        queue_frame(sel_b, 8'($urandom_range(0, 255)), {2'b00, want}, plen,
                    $urandom_range(0, 3) == 0);
      end else if (pick < 14) begin
        t = {2'b00, want};
        t = t + 8'($urandom_range(1, 40));
        queue_frame(sel_b, 8'($urandom_range(0, 255)), t, plen, 1'b0);
      end else if (pick == 14) begin
        do t = 8'($urandom_range(0, 255)); while (t == code_a || t == code_b);
        push_item(START_BYTE, 1'b0);
        push_item(t, 1'b0);
      end else if (pick < 17) begin
        push_item(8'($urandom_range(0, 255)), 1'b1);
      end else if (pick == 17) begin
        push_item(START_BYTE, 1'b0);
        push_item(sel_b ? code_b : code_a, 1'b0);
        push_item(8'($urandom_range(0, 255)), 1'b0);
        push_item(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        repeat ($urandom_range(1, 3)) push_item(8'($urandom_range(0, 255)), 1'b0);
      end
    end
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_LIMIT) $display("%0t: output beat %0d: %s", $time, beat_no, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Compare one accepted output beat with the oldest expectation.
  task automatic check_beat();
    result_beat_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch($sformatf("unexpected beat, tdata 0x%0h", m_axis_tdata));
      return;
    end
    want = expected_beats.pop_front();
    check_field("kind",           CNT_W'(m_axis_tuser),        CNT_W'(want.kind));
    check_field("status",         CNT_W'(m_axis_tdata[1:0]),   CNT_W'(want.status));
    check_field("sensor_kind",    CNT_W'(m_axis_tdata[2]),     CNT_W'(want.sensor_kind));
    check_field("frame_addr",     CNT_W'(m_axis_tdata[10:3]),  CNT_W'(want.address));
    check_field("payload_byte",   CNT_W'(m_axis_tdata[18:11]), CNT_W'(want.payload));
    check_field("payload_index",  CNT_W'(m_axis_tdata[23:19]), CNT_W'(want.index));
    check_field("last",           CNT_W'(m_axis_tlast),        CNT_W'(want.last));
    check_field("good_count_a",   m_axis_tdata[39:24],         want.count_a);
    check_field("good_count_b",   m_axis_tdata[55:40],         want.count_b);
    check_field("rx_error_count", m_axis_tdata[71:56],         want.count_err);
  endtask

  // Input driver: holds a beat until it is taken, idles in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tuser);
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(0, 7);
          s_axis_tvalid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          next_item = pending_bytes.pop_front();
          s_axis_tdata  <= next_item.data;
          s_axis_tuser  <= next_item.err;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each accepted beat, stalls in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_beat();
        beat_no++;
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        sink_stall = $urandom_range(0, 7);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || psel || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles = 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stuck_cycles++;
    end
  end

  // Register write: setup cycle, then access cycle; the write lands at the access edge.
  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TYPE_A: code_a = val[7:0];
      REG_TYPE_B: code_b = val[7:0];
      REG_LEN_A:  len_a  = val[LEN_W-1:0];
      REG_LEN_B:  len_b  = val[LEN_W-1:0];
      default: ;
    endcase
  endtask

  // Wait until every queued byte is taken and every expected beat has arrived.
  // Sampling between edges sees the driver and monitor updates of the last edge.
  task automatic wait_drained(int settle);
    do @(negedge clk);
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_beats.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_config(logic [7:0] ta, logic [7:0] tb, logic [LEN_W-1:0] la,
                              logic [LEN_W-1:0] lb);
    reg_write(REG_TYPE_A, {24'h0, ta});
    reg_write(REG_TYPE_B, {24'h0, tb});
    reg_write(REG_LEN_A, {26'h0, la});
    reg_write(REG_LEN_B, {26'h0, lb});
  endtask

  initial begin
    logic [7:0] split_sum;
    logic [7:0] split_byte;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part with reset register values.
    push_item(8'hFF, 1'b1);                     // receive error while hunting
    push_item(8'h00, 1'b0);                     // noise
    push_item(START_BYTE, 1'b0);                // start byte as type: dropped, not a restart
    push_item(START_BYTE, 1'b0);
    push_item(START_BYTE, 1'b0);                // length does not match the kind
    push_item(TYPE_B_RESET, 1'b0);
    push_item(8'h05, 1'b0);
    push_item({2'b00, LEN_A_RESET}, 1'b0);
    push_item(START_BYTE, 1'b0);                // receive error inside a frame
    push_item(TYPE_A_RESET, 1'b0);
    push_item(8'h00, 1'b1);
    queue_frame(1'b0, 8'hFF, {2'b00, LEN_A_RESET}, int'(LEN_A_RESET), 1'b0);
    wait_drained(8);

    // Extreme codes and lengths; end on a frame cut off after its length byte.
    write_config(8'h00, 8'hFF, 6'd1, 6'd32);
    queue_frame(1'b1, 8'h00, 8'd32, 32, 1'b0);
    queue_random(15);
    push_item(8'h00, 1'b1);
    split_byte = 8'($urandom_range(0, 255));
    split_sum  = START_BYTE ^ code_a ^ split_byte ^ 8'd1;
    push_item(START_BYTE, 1'b0);
    push_item(code_a, 1'b0);
    push_item(split_byte, 1'b0);
    push_item(8'd1, 1'b0);
    wait_drained(8);

    // Equal type codes and an invalid zero length; the open frame keeps its latched length.
    write_config(8'h5A, 8'h5A, 6'd3, 6'd0);
    split_byte = 8'($urandom_range(0, 255));
    split_sum  = split_sum ^ split_byte;
    push_item(split_byte, 1'b0);
    push_item(split_sum, 1'b0);
    push_item(8'($urandom_range(0, 255)), 1'b0);
    queue_random(20);
    wait_drained(8);

    // Random codes, one kind with a length beyond the payload store.
    write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 6'd33,
                 LEN_W'($urandom_range(1, 5)));
    queue_random(20);
    wait_drained(8);

    // Final stretch without any idling on either side.
    write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 LEN_W'($urandom_range(1, 6)), LEN_W'($urandom_range(1, 6)));
    no_idle = 1;
    queue_random(25);
    wait_drained(80);

    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
